>>> hw/rtl/pps_pkg.sv
package pps_pkg;

    localparam int SLOTS      = 16;
    localparam int TIME_BITS  = 16;
    localparam int PRIO_BITS  = 8;
    localparam int SLOT_BITS  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int FIELD_BITS = 16;
    localparam int CALC_BITS  = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
    localparam int SUM_BITS   = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic                  en;
        logic [FIELD_BITS-1:0] id;
        logic [FIELD_BITS-1:0] arrival;
        logic [PRIO_BITS-1:0]  prio;
        logic [FIELD_BITS-1:0] burst;
    } load_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] idx;
    } dec_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_BITS-1:0]  idx;
        logic [PRIO_BITS-1:0]  prio;
        logic [FIELD_BITS-1:0] id;
        logic [FIELD_BITS-1:0] arrival;
        logic [FIELD_BITS-1:0] burst;
        logic [FIELD_BITS-1:0] remaining;
    } cand_t;

endpackage

>>> hw/rtl/pps_cell.sv
module pps_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [pps_pkg::SLOT_BITS-1:0]   cell_index,
    input  logic [pps_pkg::TIME_BITS-1:0]   clock_now,
    input  pps_pkg::load_t                  load,
    input  pps_pkg::dec_t                   dec,
    input  pps_pkg::cand_t                  cand_in,
    output pps_pkg::cand_t                  cand_out
);

    logic [pps_pkg::FIELD_BITS-1:0] id_reg;
    logic [pps_pkg::FIELD_BITS-1:0] arrival_reg;
    logic [pps_pkg::PRIO_BITS-1:0]  prio_reg;
    logic [pps_pkg::FIELD_BITS-1:0] burst_reg;
    logic [pps_pkg::FIELD_BITS-1:0] remaining_reg;
    logic [pps_pkg::FIELD_BITS-1:0] remaining_next;
    pps_pkg::cand_t                 cand_reg;
    pps_pkg::cand_t                 cand_next;
    logic                           eligible;
    logic                           take;

    assign eligible = (remaining_reg != '0) &&
                      (pps_pkg::CALC_BITS'(arrival_reg) <= pps_pkg::CALC_BITS'(clock_now));
    assign take     = eligible && (!cand_in.found || (prio_reg < cand_in.prio));

    always_comb begin
        cand_next = cand_in;
        if (take) begin
            cand_next.found     = 1'b1;
            cand_next.idx       = cell_index;
            cand_next.prio      = prio_reg;
            cand_next.id        = id_reg;
            cand_next.arrival   = arrival_reg;
            cand_next.burst     = burst_reg;
            cand_next.remaining = remaining_reg;
        end
    end

    always_comb begin
        remaining_next = remaining_reg;
        if (load.en) begin
            remaining_next = load.burst;
        end else if (dec.en && (dec.idx == cell_index)) begin
            remaining_next = remaining_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            cand_reg      <= '0;
        end else begin
            remaining_reg <= remaining_next;
            cand_reg      <= cand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.en) begin
            id_reg      <= load.id;
            arrival_reg <= load.arrival;
            prio_reg    <= load.prio;
            burst_reg   <= load.burst;
        end
    end

    assign cand_out = cand_reg;

endmodule

>>> hw/rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler over a row of sixteen process cells. A load beat writes one
// cell and returns the current totals and clock, registered at the output once it is free. A tick beat
// sends a candidate down the row of cells, one registered cell per cycle, each cell keeping the
// eligible process with the smaller priority number, so a tick returns its beat only after the
// candidate has passed the whole row of cells. One beat is in work at a time, and the next is
// taken while the previous result waits at the output.
module preemptive_priority_scheduler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot [3:0], process_id [19:4], arrival_time [35:20], priority_level [43:36],
    // burst_length [59:44], zero [63:60]
    input  logic [63:0]  s_tdata,
    // command [0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ran_slot [3:0], ran_process_id [19:4], completion_time [35:20], turnaround [51:36],
    // wait_time [67:52], total_turnaround [99:68], total_wait [131:100], clock_now [147:132],
    // zero [151:148]
    output logic [151:0] m_tdata,
    // ran_valid [0], finished [1]
    output logic [1:0]   m_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [pps_pkg::TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [pps_pkg::SUM_BITS-1:0]  SUM_MAX  = '1;

    logic [1:0]                       state_reg, state_next;
    logic [pps_pkg::SLOT_BITS-1:0]    cnt_reg, cnt_next;
    logic                             cmd_reg;
    logic [pps_pkg::TIME_BITS-1:0]    clock_reg, clock_next;
    logic [pps_pkg::SUM_BITS-1:0]     sum_turn_reg, sum_turn_next;
    logic [pps_pkg::SUM_BITS-1:0]     sum_wait_reg, sum_wait_next;
    logic                             m_valid_reg;
    logic [151:0]                     m_data_reg, m_data_next;
    logic [1:0]                       m_user_reg, m_user_next;

    logic                             s_accept;
    logic                             out_free;
    logic                             commit;
    logic [3:0]                       s_slot;
    pps_pkg::load_t                   load_data;
    pps_pkg::dec_t                    dec;
    pps_pkg::cand_t                   chain [pps_pkg::SLOTS];
    pps_pkg::cand_t                   win;

    logic                             served;
    logic                             done_flag;
    logic [pps_pkg::CALC_BITS-1:0]    done_time;
    logic [pps_pkg::CALC_BITS-1:0]    turn;
    logic [pps_pkg::CALC_BITS-1:0]    wt;
    logic [pps_pkg::SUM_BITS:0]       turn_add;
    logic [pps_pkg::SUM_BITS:0]       wait_add;
    logic [pps_pkg::TIME_BITS-1:0]    clock_tick;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (state_reg == ST_FIN) && out_free;

    assign s_slot            = s_tdata[3:0];
    assign load_data.id      = s_tdata[19:4];
    assign load_data.arrival = s_tdata[35:20];
    assign load_data.prio    = pps_pkg::PRIO_BITS'(s_tdata[43:36]);
    assign load_data.burst   = s_tdata[59:44];
    assign load_data.en      = 1'b0;

    assign win       = chain[pps_pkg::SLOTS-1];
    assign served    = (cmd_reg == pps_pkg::CMD_TICK) && win.found;
    assign done_flag = served && (win.remaining == 16'd1);

    assign dec.en  = commit && served;
    assign dec.idx = win.idx;

    genvar gi;
    generate
        for (gi = 0; gi < pps_pkg::SLOTS; gi++) begin : g_cell
            pps_pkg::load_t cell_load;
            pps_pkg::cand_t cell_in;

            always_comb begin
                cell_load    = load_data;
                cell_load.en = s_accept && (s_tuser[0] == pps_pkg::CMD_LOAD) &&
                               (32'(s_slot) == gi);
            end

            if (gi == 0) begin : g_head
                assign cell_in = '0;
            end else begin : g_body
                assign cell_in = chain[gi-1];
            end

            pps_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cell_index (pps_pkg::SLOT_BITS'(gi)),
                .clock_now  (clock_reg),
                .load       (cell_load),
                .dec        (dec),
                .cand_in    (cell_in),
                .cand_out   (chain[gi])
            );
        end
    endgenerate

    assign clock_tick = (clock_reg < TIME_MAX) ? clock_reg + 1'b1 : clock_reg;
    assign done_time  = pps_pkg::CALC_BITS'(clock_tick);
    assign turn       = done_time - pps_pkg::CALC_BITS'(win.arrival);
    assign wt         = (turn >= pps_pkg::CALC_BITS'(win.burst)) ?
                        turn - pps_pkg::CALC_BITS'(win.burst) : '0;
    assign turn_add   = {1'b0, sum_turn_reg} + (pps_pkg::SUM_BITS + 1)'(turn);
    assign wait_add   = {1'b0, sum_wait_reg} + (pps_pkg::SUM_BITS + 1)'(wt);

    always_comb begin
        sum_turn_next = sum_turn_reg;
        sum_wait_next = sum_wait_reg;
        clock_next    = clock_reg;
        if (commit) begin
            if (done_flag) begin
                sum_turn_next = turn_add[pps_pkg::SUM_BITS] ? SUM_MAX :
                                turn_add[pps_pkg::SUM_BITS-1:0];
                sum_wait_next = wait_add[pps_pkg::SUM_BITS] ? SUM_MAX :
                                wait_add[pps_pkg::SUM_BITS-1:0];
            end
            if (cmd_reg == pps_pkg::CMD_TICK) begin
                clock_next = clock_tick;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_accept) begin
                    state_next = (s_tuser[0] == pps_pkg::CMD_TICK) ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == pps_pkg::SLOT_BITS'(pps_pkg::SLOTS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_data_next          = '0;
        m_data_next[99:68]   = sum_turn_next;
        m_data_next[131:100] = sum_wait_next;
        m_data_next[147:132] = 16'(clock_next);
        m_user_next          = {done_flag, served};
        if (served) begin
            m_data_next[3:0]  = 4'(win.idx);
            m_data_next[19:4] = win.id;
        end
        if (done_flag) begin
            m_data_next[35:20] = 16'(done_time);
            m_data_next[51:36] = 16'(turn);
            m_data_next[67:52] = 16'(wt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            clock_reg    <= '0;
            sum_turn_reg <= '0;
            sum_wait_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clock_reg    <= clock_next;
            sum_turn_reg <= sum_turn_next;
            sum_wait_reg <= sum_wait_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_tuser[0];
        end
        if (commit) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> bench/tb_preemptive_priority_scheduler.sv
module tb_preemptive_priority_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int     CYCLE_LIMIT  = 10_000_000;
    localparam int     RANDOM_BEATS = 1550;
    localparam int     HOLD_AFTER   = 400;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     PRINT_LIMIT  = 40;
    localparam longint SUM_CEILING  = 64'hFFFF_FFFF;

    typedef struct packed {
        logic                  ran_valid;
        logic                  finished;
        logic [SLOT_BITS-1:0]  ran_slot;
        logic [FIELD_BITS-1:0] ran_pid;
        logic [FIELD_BITS-1:0] completion;
        logic [FIELD_BITS-1:0] turnaround;
        logic [FIELD_BITS-1:0] wait_time;
        logic [SUM_BITS-1:0]   total_turn;
        logic [SUM_BITS-1:0]   total_wait;
        logic [TIME_BITS-1:0]  clock_now;
    } sched_result_t;

    class schedule_board;
        logic [FIELD_BITS-1:0] pid_mem   [SLOTS];
        logic [FIELD_BITS-1:0] arr_mem   [SLOTS];
        logic [PRIO_BITS-1:0]  prio_mem  [SLOTS];
        logic [FIELD_BITS-1:0] burst_mem [SLOTS];
        logic [FIELD_BITS-1:0] left_mem  [SLOTS];
        logic [TIME_BITS-1:0]  clock_count;
        logic [SUM_BITS-1:0]   sum_turn;
        logic [SUM_BITS-1:0]   sum_wait;
        sched_result_t         due_results[$];
        int errors;
        int n_loads;
        int n_ticks;
        int n_done;
        int n_idle;
        int n_clamped;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                pid_mem[i]   = '0;
                arr_mem[i]   = '0;
                prio_mem[i]  = '0;
                burst_mem[i] = '0;
                left_mem[i]  = '0;
            end
            clock_count = '0;
            sum_turn    = '0;
            sum_wait    = '0;
            errors      = 0;
            n_loads     = 0;
            n_ticks     = 0;
            n_done      = 0;
            n_idle      = 0;
            n_clamped   = 0;
        endfunction

        function void note_accepted(input logic cmd, input logic [SLOT_BITS-1:0] slot,
                                    input logic [FIELD_BITS-1:0] pid,
                                    input logic [FIELD_BITS-1:0] arrival,
                                    input logic [PRIO_BITS-1:0] prio,
                                    input logic [FIELD_BITS-1:0] burst);
            sched_result_t r;
            bit     found;
            int     best;
            int     i;
            longint done_at;
            longint turn;
            longint wt;
            longint acc;
            r = '0;
            if (cmd == CMD_LOAD) begin
                n_loads++;
                pid_mem[slot]   = pid;
                arr_mem[slot]   = arrival;
                prio_mem[slot]  = prio;
                burst_mem[slot] = burst;
                left_mem[slot]  = burst;
            end else begin
                n_ticks++;
                found = 1'b0;
                best  = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (arr_mem[i] <= clock_count && left_mem[i] != '0 &&
                        (!found || prio_mem[i] < prio_mem[best])) begin
                        found = 1'b1;
                        best  = i;
                    end
                end
                if (found) begin
                    r.ran_valid    = 1'b1;
                    r.ran_slot     = SLOT_BITS'(best);
                    r.ran_pid      = pid_mem[best];
                    left_mem[best] = left_mem[best] - 1'b1;
                    if (left_mem[best] == '0) begin
                        n_done++;
                        done_at = longint'(clock_count);
                        if (clock_count != '1)
                            done_at = done_at + 1;
                        turn = done_at - longint'(arr_mem[best]);
                        if (turn >= longint'(burst_mem[best])) begin
                            wt = turn - longint'(burst_mem[best]);
                        end else begin
                            wt = 0;
                            n_clamped++;
                        end
                        r.finished   = 1'b1;
                        r.completion = FIELD_BITS'(done_at);
                        r.turnaround = FIELD_BITS'(turn);
                        r.wait_time  = FIELD_BITS'(wt);
                        acc = longint'(sum_turn) + turn;
                        sum_turn = (acc > SUM_CEILING) ? '1 : SUM_BITS'(acc);
                        acc = longint'(sum_wait) + wt;
                        sum_wait = (acc > SUM_CEILING) ? '1 : SUM_BITS'(acc);
                    end
                end else begin
                    n_idle++;
                end
                if (clock_count != '1)
                    clock_count = clock_count + 1'b1;
            end
            r.total_turn = sum_turn;
            r.total_wait = sum_wait;
            r.clock_now  = clock_count;
            due_results.push_back(r);
        endfunction

        function void check_field(input string what, input logic [SUM_BITS-1:0] want,
                                  input logic [SUM_BITS-1:0] got);
            if (want !== got) begin
                if (errors < PRINT_LIMIT)
                    $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [151:0] data, input logic [1:0] user);
            sched_result_t e;
            if (due_results.size() == 0) begin
                if (errors < PRINT_LIMIT)
                    $display("%0t ns: result beat expected none, got tdata %0h tuser %0h",
                             $time, data, user);
                errors++;
                return;
            end
            e = due_results.pop_front();
            check_field("ran_valid", e.ran_valid, user[0]);
            check_field("finished", e.finished, user[1]);
            check_field("ran_slot", e.ran_slot, data[3:0]);
            check_field("ran_process_id", e.ran_pid, data[19:4]);
            check_field("completion_time", e.completion, data[35:20]);
            check_field("turnaround", e.turnaround, data[51:36]);
            check_field("wait_time", e.wait_time, data[67:52]);
            check_field("total_turnaround", e.total_turn, data[99:68]);
            check_field("total_wait", e.total_wait, data[131:100]);
            check_field("clock_now", e.clock_now, data[147:132]);
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;

    schedule_board board;
    bit            gaps_on;
    int            cycle_count = 0;

    preemptive_priority_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_beat(input logic cmd, input logic [SLOT_BITS-1:0] slot,
                             input logic [FIELD_BITS-1:0] pid,
                             input logic [FIELD_BITS-1:0] arrival,
                             input logic [PRIO_BITS-1:0] prio,
                             input logic [FIELD_BITS-1:0] burst);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, burst, prio, arrival, pid, slot};
        do @(posedge aclk); while (!s_tready);
        board.note_accepted(cmd, slot, pid, arrival, prio, burst);
    endtask

    task automatic send_load(input int slot, input int pid, input int arrival,
                             input int prio, input int burst);
        send_beat(CMD_LOAD, SLOT_BITS'(slot), FIELD_BITS'(pid), FIELD_BITS'(arrival),
                  PRIO_BITS'(prio), FIELD_BITS'(burst));
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, SLOT_BITS'($urandom), FIELD_BITS'($urandom),
                  FIELD_BITS'($urandom), PRIO_BITS'($urandom), FIELD_BITS'($urandom));
    endtask

    // A batch of processes arriving close to the current clock, followed by enough ticks
    // to see most of them through, with a little slack for idle ticks.
    task automatic run_batch();
        int procs;
        int need;
        int burst;
        int k;
        procs = $urandom_range(1, 4);
        need  = 0;
        for (k = 0; k < procs; k++) begin
            burst = $urandom_range(1, 6);
            send_load($urandom_range(0, SLOTS - 1), $urandom,
                      int'(board.clock_count) + $urandom_range(0, 6),
                      $urandom_range(0, 255), burst);
            need += burst;
        end
        repeat (need + $urandom_range(0, 8)) send_tick();
    endtask

    task automatic random_mix();
        gaps_on = ($urandom_range(0, 5) != 0);
        case ($urandom_range(0, 7))
            0: send_load($urandom, $urandom, $urandom, $urandom, $urandom);
            1: send_load($urandom_range(0, SLOTS - 1), $urandom, $urandom, $urandom, 0);
            2: repeat ($urandom_range(1, 10)) send_tick();
            default: run_batch();
        endcase
    endtask

    initial begin
        int stall;
        int seen;
        m_tready = 1'b0;
        seen     = 0;
        @(posedge aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            if (seen == HOLD_AFTER)
                stall = HOLD_CYCLES;
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata, m_tuser);
            seen++;
        end
    end

    initial begin
        int base;
        board    = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_LOAD;
        gaps_on  = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_tick();
        send_load(0, 16'hFFFF, 0, 8'hFF, 0);
        send_load(15, 0, 16'hFFFF, 0, 16'hFFFF);
        send_load(3, 16'h1234, 1, 5, 2);
        send_load(7, 16'hABCD, 1, 5, 1);
        send_tick();
        send_load(2, 16'h0F0F, 0, 1, 1);
        send_tick();
        send_tick();
        send_load(7, 16'h5555, 0, 9, 3);
        send_tick();
        send_load(12, 16'hAAAA, 16'h8000, 8'h80, 16'h8000);
        send_tick();
        send_tick();
        send_tick();
        send_load(4, 16'h0001, 0, 0, 0);
        send_tick();

        base = board.n_loads + board.n_ticks;
        while (board.n_loads + board.n_ticks - base < RANDOM_BEATS)
            random_mix();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d load beats and %0d tick beats: %0d completions, %0d idle ticks,",
                 board.n_loads, board.n_ticks, board.n_done, board.n_idle);
        $display("%0d clamped waits, one long output stall that backed up the input, %0d cycles.",
                 board.n_clamped, cycle_count);
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
